### sv/tpmd_pkg.sv
// Package for the two-axis proportional move drive.
// Holds opcodes, register indexes, fixed field widths, the sequencer state type
// and the sequencer control struct. It depends on nothing else.
package tpmd_pkg;

	localparam int GOAL_W    = 17;
	localparam int SPAN_W    = 16;
	localparam int TOL_W     = 10;
	localparam int SPEED_W   = 8;
	localparam int DRIVE_W   = 8;
	localparam int MAG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int MUL_A_W   = 16;

	// Opcodes of an input transaction.
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd2;

	localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd2125;
	localparam logic [TOL_W-1:0]  TOL_RESET  = 10'd10;

	// Q1.15 value of 1.0 for the normalized goals.
	localparam logic [MUL_A_W-1:0] GOAL_ONE  = 16'd32768;
	localparam int                 GOAL_FRAC = 15;

	localparam logic [SPEED_W-1:0] DRIVE_MAX = 8'd100;
	localparam logic [SPEED_W-1:0] DRIVE_MIN = 8'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GOAL_X,
		ST_GOAL_Y,
		ST_DIST,
		ST_DIV,
		ST_MAG_X,
		ST_MAG_Y,
		ST_TICK,
		ST_EMIT
	} state_t;

	// Control decoded from the sequencer state.
	typedef struct packed {
		logic item_ready;
		logic sel_y;
		logic sel_mag;
	} seq_ctl_t;

endpackage

### sv/tpmd_if.sv
// Handshake channel interfaces of the two-axis proportional move drive.
// Uses the field widths of tpmd_pkg.
interface tpmd_item_if
	import tpmd_pkg::*;
	#(parameter int POSITION_BITS = 17) ();
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic signed [GOAL_W-1:0]        goal_x;
	logic signed [GOAL_W-1:0]        goal_y;
	logic [SPEED_W-1:0]              base_speed;
	logic signed [POSITION_BITS-1:0] position_x;
	logic signed [POSITION_BITS-1:0] position_y;

	modport source (output valid, opcode, goal_x, goal_y, base_speed, position_x,
		position_y, input ready);
	modport sink (input valid, opcode, goal_x, goal_y, base_speed, position_x,
		position_y, output ready);
endinterface

interface tpmd_result_if
	import tpmd_pkg::*;
	();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive_x;
	logic signed [DRIVE_W-1:0] drive_y;
	logic                      move_done;

	modport source (output valid, drive_x, drive_y, move_done, input ready);
	modport sink (input valid, drive_x, drive_y, move_done, output ready);
endinterface

### sv/two_axis_proportional_move_drive_core.sv
// Top level of the two-axis proportional move drive: sequencer, shared multiplier,
// tick evaluation and result register. Depends on tpmd_pkg, tpmd_if and tpmd_div.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-----------------------------------------------------------
//  item     | in        | opcode, goal_x, goal_y, base_speed, position_x, position_y
//  result   | out       | drive_x, drive_y, move_done
//  cfg_*    | in        | write enable, register index, 16-bit write data
//
// A start transaction steps through the goal, distance, divide and magnitude states;
// the bit-per-cycle divider that forms the speed ratio is the longest step. When both
// distances are zero the divider is skipped. A tick transaction passes the tick and
// emit states. Reset is asynchronous and brings the block to its idle state with
// both axes counted as reached. The block takes a new item while a finished result
// still waits in the output register; only the final hand-over step waits on a stall.
module two_axis_proportional_move_drive_core
	import tpmd_pkg::*;
#(
	parameter int RATIO_FRAC_BITS = 16,
	parameter int POSITION_BITS   = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	tpmd_item_if.sink            item,
	tpmd_result_if.source        result
);

	localparam int F  = RATIO_FRAC_BITS;
	localparam int PB = POSITION_BITS;
	localparam int RW = F + 1;
	// The multiplier's second operand carries either a span or a ratio.
	localparam int MB = (RW > SPAN_W) ? RW : SPAN_W;
	localparam int PW = MUL_A_W + MB;
	localparam int TW = (PB > GOAL_W) ? PB : GOAL_W;
	localparam logic [RW-1:0] RATIO_ONE = {1'b1, {F{1'b0}}};
	localparam logic [PB-1:0] POS_LIM   = {1'b0, {(PB - 1){1'b1}}};

	// Configuration registers.
	logic [SPAN_W-1:0] span_x_q;
	logic [SPAN_W-1:0] span_y_q;
	logic [TOL_W-1:0]  tol_q;

	// Move state.
	state_t                 state_q;
	state_t                 state_d;
	seq_ctl_t               ctl;
	logic signed [PB-1:0]   goal_ticks_x_q;
	logic signed [PB-1:0]   goal_ticks_y_q;
	logic [RW-1:0]          ratio_x_q;
	logic [RW-1:0]          ratio_y_q;
	logic [SPEED_W-1:0]     move_speed_q;
	logic                   arrived_x_q;
	logic                   arrived_y_q;
	logic                   long_x_q;
	logic [MAG_W-1:0]       mag_x_q;
	logic [MAG_W-1:0]       mag_y_q;

	// Latched transaction payload.
	logic signed [GOAL_W-1:0] goal_x_q;
	logic signed [GOAL_W-1:0] goal_y_q;
	logic signed [PB-1:0]     pos_x_q;
	logic signed [PB-1:0]     pos_y_q;

	// Staged result and output register.
	logic signed [DRIVE_W-1:0] res_dx_q;
	logic signed [DRIVE_W-1:0] res_dy_q;
	logic                      res_done_q;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] out_dx_q;
	logic signed [DRIVE_W-1:0] out_dy_q;
	logic                      out_done_q;

	// Datapath signals.
	logic                 accept;
	logic                 slot_free;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MB-1:0]        mul_b;
	logic [PW-1:0]        prod;
	logic [TW-1:0]        tick_ext;
	logic [PB-1:0]        tick_sat;
	logic [MAG_W-1:0]     mag_new;
	logic [PB-1:0]        dist_x;
	logic [PB-1:0]        dist_y;
	logic                 x_longer;
	logic                 both_zero;
	logic                 div_start;
	logic                 div_done;
	logic [RW-1:0]        div_quo;
	logic                 reach_x;
	logic                 reach_y;
	logic                 arr_x_new;
	logic                 arr_y_new;

	// Absolute difference of two positions; it always fits PB unsigned bits.
	function automatic logic [PB-1:0] abs_diff(input logic signed [PB-1:0] a,
		input logic signed [PB-1:0] b);
		logic signed [PB:0] d;
		d = {a[PB-1], a} - {b[PB-1], b};
		return d[PB] ? PB'(-d) : PB'(d);
	endfunction

	// Clamps a normalized Q1.15 goal to 0..1.0.
	function automatic logic [MUL_A_W-1:0] clamp_goal(input logic signed [GOAL_W-1:0] g);
		logic [MUL_A_W-1:0] r;
		if (g[GOAL_W-1])
			r = '0;
		else if (g > $signed({1'b0, GOAL_ONE}))
			r = GOAL_ONE;
		else
			r = g[MUL_A_W-1:0];
		return r;
	endfunction

	// Signed drive toward the goal with a given magnitude.
	function automatic logic signed [DRIVE_W-1:0] drive_of(input logic signed [PB-1:0] pos,
		input logic signed [PB-1:0] goal, input logic [MAG_W-1:0] mag);
		logic [DRIVE_W-1:0] m;
		m = {1'b0, mag};
		return (pos < goal) ? m : DRIVE_W'(-m);
	endfunction

	assign accept    = item.valid && item.ready;
	assign slot_free = !out_valid_q || result.ready;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_x_q <= SPAN_RESET;
			span_y_q <= SPAN_RESET;
			tol_q    <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPAN_X: span_x_q <= cfg_data;
				REG_SPAN_Y: span_y_q <= cfg_data;
				REG_TOL:    tol_q    <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid)
					state_d = (item.opcode == OP_START) ? ST_GOAL_X : ST_TICK;
			end
			ST_GOAL_X: state_d = ST_GOAL_Y;
			ST_GOAL_Y: state_d = ST_DIST;
			ST_DIST:   state_d = both_zero ? ST_MAG_X : ST_DIV;
			ST_DIV: begin
				if (div_done)
					state_d = ST_MAG_X;
			end
			ST_MAG_X: state_d = ST_MAG_Y;
			ST_MAG_Y: state_d = ST_EMIT;
			ST_TICK:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE:   ctl.item_ready = 1'b1;
			ST_GOAL_Y: ctl.sel_y      = 1'b1;
			ST_MAG_X:  ctl.sel_mag    = 1'b1;
			ST_MAG_Y: begin
				ctl.sel_mag = 1'b1;
				ctl.sel_y   = 1'b1;
			end
			default: ;
		endcase
	end

	assign item.ready = ctl.item_ready;

	// The one multiplier is shared: goal times span for the tick targets, then
	// move speed times ratio for the drive magnitudes.
	always_comb begin
		if (ctl.sel_mag) begin
			mul_a = MUL_A_W'(move_speed_q);
			mul_b = ctl.sel_y ? MB'(ratio_y_q) : MB'(ratio_x_q);
		end else begin
			mul_a = ctl.sel_y ? clamp_goal(goal_y_q) : clamp_goal(goal_x_q);
			mul_b = ctl.sel_y ? MB'(span_y_q) : MB'(span_x_q);
		end
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	// Goal in ticks, saturated to the largest positive encoder value.
	assign tick_ext = TW'(prod[GOAL_FRAC +: GOAL_W]);
	assign tick_sat = (tick_ext > TW'(POS_LIM)) ? POS_LIM : PB'(tick_ext);

	// Drive magnitude clamped to the motor command range.
	always_comb begin
		logic [SPEED_W-1:0] m;
		m = SPEED_W'(prod >> F);
		if (m < DRIVE_MIN)
			mag_new = MAG_W'(DRIVE_MIN);
		else if (m > DRIVE_MAX)
			mag_new = MAG_W'(DRIVE_MAX);
		else
			mag_new = m[MAG_W-1:0];
	end

	// Distances from the start transaction's encoders; the shorter axis is divided
	// by the longer one.
	assign dist_x    = abs_diff(goal_ticks_x_q, pos_x_q);
	assign dist_y    = abs_diff(goal_ticks_y_q, pos_y_q);
	assign x_longer  = dist_x > dist_y;
	assign both_zero = (dist_x == '0) && (dist_y == '0);
	assign div_start = (state_q == ST_DIST) && !both_zero;

	tpmd_div #(
		.NB(PB),
		.QB(RW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (x_longer ? dist_y : dist_x),
		.den   (x_longer ? dist_x : dist_y),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Tick evaluation: the reach test uses this tick's encoders before the drive.
	assign reach_x   = abs_diff(pos_x_q, goal_ticks_x_q) < PB'(tol_q);
	assign reach_y   = abs_diff(pos_y_q, goal_ticks_y_q) < PB'(tol_q);
	assign arr_x_new = arrived_x_q || reach_x;
	assign arr_y_new = arrived_y_q || reach_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			goal_ticks_x_q <= '0;
			goal_ticks_y_q <= '0;
			ratio_x_q      <= RATIO_ONE;
			ratio_y_q      <= RATIO_ONE;
			move_speed_q   <= '0;
			arrived_x_q    <= 1'b1;
			arrived_y_q    <= 1'b1;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && item.opcode == OP_START)
				move_speed_q <= item.base_speed;
			if (state_q == ST_GOAL_X)
				goal_ticks_x_q <= tick_sat;
			if (state_q == ST_GOAL_Y)
				goal_ticks_y_q <= tick_sat;
			if (state_q == ST_DIST && both_zero) begin
				ratio_x_q <= RATIO_ONE;
				ratio_y_q <= RATIO_ONE;
			end
			if (state_q == ST_DIV && div_done) begin
				ratio_x_q <= long_x_q ? RATIO_ONE : div_quo;
				ratio_y_q <= long_x_q ? div_quo : RATIO_ONE;
			end
			if (state_q == ST_MAG_Y) begin
				arrived_x_q <= 1'b0;
				arrived_y_q <= 1'b0;
			end
			if (state_q == ST_TICK) begin
				arrived_x_q <= arr_x_new;
				arrived_y_q <= arr_y_new;
			end
			if (state_q == ST_EMIT && slot_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			goal_x_q <= item.goal_x;
			goal_y_q <= item.goal_y;
			pos_x_q  <= item.position_x;
			pos_y_q  <= item.position_y;
		end
		if (state_q == ST_DIST)
			long_x_q <= x_longer;
		if (state_q == ST_MAG_X)
			mag_x_q <= mag_new;
		if (state_q == ST_MAG_Y) begin
			mag_y_q    <= mag_new;
			res_dx_q   <= '0;
			res_dy_q   <= '0;
			res_done_q <= 1'b0;
		end
		if (state_q == ST_TICK) begin
			res_dx_q   <= arr_x_new ? '0 : drive_of(pos_x_q, goal_ticks_x_q, mag_x_q);
			res_dy_q   <= arr_y_new ? '0 : drive_of(pos_y_q, goal_ticks_y_q, mag_y_q);
			res_done_q <= arr_x_new && arr_y_new;
		end
		if (state_q == ST_EMIT && slot_free) begin
			out_dx_q   <= res_dx_q;
			out_dy_q   <= res_dy_q;
			out_done_q <= res_done_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.drive_x   = out_dx_q;
	assign result.drive_y   = out_dy_q;
	assign result.move_done = out_done_q;

	// A finished move never carries a nonzero drive.
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.move_done |-> result.drive_x == '0 && result.drive_y == '0)
		else $error("drive present on a finished move");

	// Only the end of a start sequence clears the reached flags.
	a_arrive_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(arrived_x_q) || $fell(arrived_y_q) |-> $past(state_q) == ST_MAG_Y)
		else $error("reached flag cleared outside a start");

	// The shorter distance never exceeds the longer, so a ratio stays at most 1.0.
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_quo <= RATIO_ONE)
		else $error("speed ratio above 1.0");

	// Drive commands stay within the motor range.
	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.drive_x <= 8'sd100 && result.drive_x >= -8'sd100
			&& result.drive_y <= 8'sd100 && result.drive_y >= -8'sd100)
		else $error("drive command out of range");

endmodule

### sv/tpmd_div.sv
// Bit-serial restoring divider of the move drive: quotient = num * 2^(QB-1) / den.
// Needs num <= den; one quotient bit per cycle. Depends on no package.
module tpmd_div #(
	parameter int NB = 17,
	parameter int QB = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NB-1:0] num,
	input  logic [NB-1:0] den,
	output logic          done,
	output logic [QB-1:0] quo
);

	localparam int CW = $clog2(QB);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NB:0]   rem_q;
	logic [NB-1:0] den_q;
	logic [QB-1:0] quo_q;
	logic          ge;
	logic [NB:0]   rem_sub;

	// The remainder always stays below twice the divisor, so NB+1 bits hold it.
	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(QB - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= {rem_sub[NB-1:0], 1'b0};
			quo_q <= {quo_q[QB-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
